>>> rtl/ray_paraboloid_intersect_defines.svh
// assertion macros used by the checker file
`ifndef RAY_PARABOLOID_INTERSECT_DEFINES_SVH
`define RAY_PARABOLOID_INTERSECT_DEFINES_SVH

// clocked assertion, off while reset is high
`define RPI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpi check failed");

// clocked assertion that also holds across reset
`define RPI_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rpi check failed");

`endif

>>> rtl/rpi_pkg.sv
package rpi_pkg;

   localparam int QW              = 64;
   localparam int HALF            = QW / 2;
   localparam int PW              = 2 * QW;
   localparam int CURV_WIDTH      = 32;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int NUM_FIELDS      = 6;
   localparam int TIME_WIDTH      = 31;
   localparam int RSP_DATA_W      = 32;
   localparam int FRAC            = 16;
   localparam int SH_K            = 24;
   localparam int SH_HALF_K       = 25;
   localparam int MUL_LAT         = 3;
   localparam int SQRT_STEPS      = 40;
   localparam int SQRT_RAD        = 2 * SQRT_STEPS;
   localparam int SQRT_REM        = SQRT_STEPS + 2;
   localparam int DIV_STEPS       = QW;
   localparam int DIV_LAT         = DIV_STEPS + 2;
   localparam int FRONT_LAT       = 1 + MUL_LAT + 1 + MUL_LAT + 1 + MUL_LAT + 3;
   localparam int BACK_LAT        = 1 + SQRT_STEPS + 2 + DIV_LAT + MUL_LAT + 1 + DIV_LAT + 1;
   localparam int FIFO_DEPTH      = 4;

   typedef logic signed [QW-1:0] q_type;

   localparam q_type Q_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam q_type Q_MIN = {1'b1, {(QW-1){1'b0}}};
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   typedef struct packed {
      q_type a;
      q_type b;
      q_type c;
      q_type disc;
   } coef_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [SQRT_REM-1:0]   rem;
      logic [SQRT_STEPS-1:0] root;
      logic [SQRT_RAD-1:0]   rad;
   } sqrt_st_type;

   typedef struct packed {
      logic [QW-1:0] rem;
      logic [QW-1:0] quo;
      logic [QW-1:0] dm;
      logic          neg;
      logic          over;
      logic          dz;
   } div_st_type;

   function automatic q_type sat_add(q_type a, q_type b);
      q_type s;
      s = a + b;
      if (a[QW-1] == b[QW-1] && s[QW-1] != a[QW-1]) s = a[QW-1] ? Q_MIN : Q_MAX;
      return s;
   endfunction

   function automatic q_type sat_sub(q_type a, q_type b);
      q_type s;
      s = a - b;
      if (a[QW-1] != b[QW-1] && s[QW-1] != a[QW-1]) s = a[QW-1] ? Q_MIN : Q_MAX;
      return s;
   endfunction

   function automatic q_type sat_neg(q_type a);
      return (a == Q_MIN) ? Q_MAX : -a;
   endfunction

   function automatic logic [QW-1:0] mag(q_type a);
      return a[QW-1] ? QW'(-a) : QW'(a);
   endfunction

   function automatic q_type pack_sat(logic neg, logic over, logic [QW-1:0] m);
      q_type r;
      if (neg) begin
         if (over || m > {1'b1, {(QW-1){1'b0}}}) r = Q_MIN;
         else r = q_type'(~m + 1'b1);
      end else begin
         if (over || m[QW-1]) r = Q_MAX;
         else r = q_type'(m);
      end
      return r;
   endfunction

   // product magnitude shifted right with truncation, then saturated
   function automatic q_type shift_sat(logic neg, logic [PW-1:0] p, int sh);
      logic [PW-1:0] s;
      s = p >> sh;
      return pack_sat(neg, |s[PW-1:QW], s[QW-1:0]);
   endfunction

   function automatic sqrt_st_type sqrt_step(sqrt_st_type s);
      logic [SQRT_REM+1:0] t;
      logic [SQRT_REM+1:0] trial;
      sqrt_st_type r;
      t       = {s.rem, s.rad[SQRT_RAD-1 -: 2]};
      trial   = {2'b00, s.root, 2'b01};
      r.rad   = s.rad << 2;
      if (t >= trial) begin
         r.rem  = SQRT_REM'(t - trial);
         r.root = {s.root[SQRT_STEPS-2:0], 1'b1};
      end else begin
         r.rem  = t[SQRT_REM-1:0];
         r.root = {s.root[SQRT_STEPS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_st_type div_step(div_st_type s);
      logic [QW:0] t;
      div_st_type r;
      r = s;
      t = {s.rem, s.quo[QW-1]};
      if (t >= {1'b0, s.dm}) begin
         r.rem = QW'(t - {1'b0, s.dm});
         r.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = t[QW-1:0];
         r.quo = {s.quo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> rtl/rpi_delay.sv
module rpi_delay import rpi_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) line_ff[i] <= line_ff[i-1];
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

>>> rtl/rpi_mul.sv
module rpi_mul import rpi_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  q_type         op_a,
   input  q_type         op_b,
   output logic [PW-1:0] prod,
   output logic          neg
);

   logic [QW-1:0]      ma_ff, mb_ff;
   logic [QW-1:0]      p00_ff, p01_ff, p10_ff, p11_ff;
   logic [PW-1:0]      prod_ff;
   logic [MUL_LAT-1:0] neg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= mag(op_a);
         mb_ff   <= mag(op_b);
         neg_ff  <= {neg_ff[MUL_LAT-2:0], op_a[QW-1] ^ op_b[QW-1]};
         p00_ff  <= ma_ff[HALF-1:0]  * mb_ff[HALF-1:0];
         p01_ff  <= ma_ff[HALF-1:0]  * mb_ff[QW-1:HALF];
         p10_ff  <= ma_ff[QW-1:HALF] * mb_ff[HALF-1:0];
         p11_ff  <= ma_ff[QW-1:HALF] * mb_ff[QW-1:HALF];
         prod_ff <= PW'(p00_ff) + (PW'(p01_ff) << HALF) + (PW'(p10_ff) << HALF)
                    + (PW'(p11_ff) << QW);
      end
   end

   assign prod = prod_ff;
   assign neg  = neg_ff[MUL_LAT-1];

endmodule

>>> rtl/rpi_sqrt.sv
module rpi_sqrt import rpi_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  q_type                 rad,
   output logic [SQRT_STEPS-1:0] root
);

   sqrt_st_type st_ff [SQRT_STEPS];
   sqrt_st_type st_in [SQRT_STEPS];
   sqrt_st_type seed;

   // radicand is the non-negative Q16 value shifted up by 16
   always_comb begin
      seed.rem  = '0;
      seed.root = '0;
      seed.rad  = {1'b0, rad[QW-2:0], FRAC'(0)};
      st_in[0]  = sqrt_step(seed);
      for (int k = 1; k < SQRT_STEPS; k++) st_in[k] = sqrt_step(st_ff[k-1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) st_ff[k] <= st_in[k];
      end
   end

   assign root = st_ff[SQRT_STEPS-1].root;

endmodule

>>> rtl/rpi_div.sv
module rpi_div import rpi_pkg::*; (
   input  logic  clock,
   input  logic  en,
   input  q_type num,
   input  q_type den,
   output q_type quo
);

   div_st_type    prep_ff;
   div_st_type    prep_in;
   div_st_type    st_ff [DIV_STEPS];
   div_st_type    st_in [DIV_STEPS];
   q_type         quo_ff;
   logic [QW-1:0] m;

   // quotient bits above the word only flag overflow, so the top part is one compare
   always_comb begin
      m            = mag(num);
      prep_in.dm   = mag(den);
      prep_in.neg  = num[QW-1] ^ den[QW-1];
      prep_in.rem  = QW'(m[QW-1:QW-FRAC]);
      prep_in.quo  = {m[QW-FRAC-1:0], FRAC'(0)};
      prep_in.over = QW'(m[QW-1:QW-FRAC]) >= prep_in.dm;
      prep_in.dz   = (prep_in.dm == '0);
      st_in[0]     = div_step(prep_ff);
      for (int k = 1; k < DIV_STEPS; k++) st_in[k] = div_step(st_ff[k-1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff <= prep_in;
         for (int k = 0; k < DIV_STEPS; k++) st_ff[k] <= st_in[k];
         quo_ff  <= st_ff[DIV_STEPS-1].dz ? '0 :
                    pack_sat(st_ff[DIV_STEPS-1].neg, st_ff[DIV_STEPS-1].over,
                             st_ff[DIV_STEPS-1].quo);
      end
   end

   assign quo = quo_ff;

endmodule

>>> rtl/rpi_fifo.sv
module rpi_fifo import rpi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  coef_type  wdata,
   input  logic      pop,
   output coef_type  rdata,
   output qstat_type stat
);

   localparam int AW = $clog2(FIFO_DEPTH);

   coef_type      slot_ff [FIFO_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wdata;
   end

   assign rdata      = slot_ff[rp_ff];
   assign stat.full  = (cnt_ff == (AW+1)'(FIFO_DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

>>> rtl/rpi_front.sv
module rpi_front import rpi_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic signed [CURV_WIDTH-1:0]              curv,
   input  qstat_type                                 qstat,
   output logic                                      push,
   output coef_type                                  coef
);

   logic signed [COORD_WIDTH-1:0] fld [NUM_FIELDS];
   logic [FRONT_LAT-1:0]          vld_ff;
   logic                          en;
   q_type                         in_ff [NUM_FIELDS];
   q_type                         m1a [NUM_FIELDS];
   q_type                         m1b [NUM_FIELDS];
   logic [PW-1:0]                 p1 [NUM_FIELDS];
   logic                          n1 [NUM_FIELDS];
   q_type                         sa_ff, sb_ff, sc_ff;
   q_type                         kq;
   logic [PW-1:0]                 pa, pb, pc, pac, pbb;
   logic                          na, nb, nc, nac, nbb;
   logic [2*QW-1:0]               zv_d;
   q_type                         a_ff, b_ff, c_ff;
   q_type                         ac2_ff, ac4_ff, bb13_ff, bb14_ff, disc_ff;
   logic [3*QW-1:0]               abc_d;

   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) fld[i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
   end

   assign en         = ~vld_ff[FRONT_LAT-1] | ~qstat.full;
   assign req_tready = en;
   assign push       = vld_ff[FRONT_LAT-1] & ~qstat.full;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[FRONT_LAT-2:0], req_tvalid};
   end

   // fields in order: x, y, z, vx, vy, vz
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_FIELDS; i++) in_ff[i] <= QW'(fld[i]);
      end
   end

   // vx*vx, vy*vy, x*vx, y*vy, x*x, y*y
   assign m1a[0] = in_ff[3];
   assign m1b[0] = in_ff[3];
   assign m1a[1] = in_ff[4];
   assign m1b[1] = in_ff[4];
   assign m1a[2] = in_ff[0];
   assign m1b[2] = in_ff[3];
   assign m1a[3] = in_ff[1];
   assign m1b[3] = in_ff[4];
   assign m1a[4] = in_ff[0];
   assign m1b[4] = in_ff[0];
   assign m1a[5] = in_ff[1];
   assign m1b[5] = in_ff[1];

   for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_m1
      rpi_mul u_mul (
         .clock(clock), .en(en), .op_a(m1a[g]), .op_b(m1b[g]), .prod(p1[g]), .neg(n1[g])
      );
   end

   rpi_delay #(.WIDTH(2*QW), .DEPTH(MUL_LAT + 1 + MUL_LAT)) u_zv (
      .clock(clock), .en(en), .din({in_ff[2], in_ff[5]}), .dout(zv_d)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= sat_add(shift_sat(n1[0], p1[0], FRAC), shift_sat(n1[1], p1[1], FRAC));
         sb_ff <= sat_add(shift_sat(n1[2], p1[2], FRAC), shift_sat(n1[3], p1[3], FRAC));
         sc_ff <= sat_add(shift_sat(n1[4], p1[4], FRAC), shift_sat(n1[5], p1[5], FRAC));
      end
   end

   assign kq = QW'(curv);

   rpi_mul u_mul_a (.clock(clock), .en(en), .op_a(sa_ff), .op_b(kq), .prod(pa), .neg(na));
   rpi_mul u_mul_b (.clock(clock), .en(en), .op_a(sb_ff), .op_b(kq), .prod(pb), .neg(nb));
   rpi_mul u_mul_c (.clock(clock), .en(en), .op_a(sc_ff), .op_b(kq), .prod(pc), .neg(nc));

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= shift_sat(na, pa, SH_HALF_K);
         b_ff <= sat_sub(shift_sat(nb, pb, SH_K), q_type'(zv_d[QW-1:0]));
         c_ff <= sat_sub(shift_sat(nc, pc, SH_HALF_K), q_type'(zv_d[2*QW-1:QW]));
      end
   end

   rpi_mul u_mul_ac (.clock(clock), .en(en), .op_a(a_ff), .op_b(c_ff), .prod(pac), .neg(nac));
   rpi_mul u_mul_bb (.clock(clock), .en(en), .op_a(b_ff), .op_b(b_ff), .prod(pbb), .neg(nbb));

   rpi_delay #(.WIDTH(3*QW), .DEPTH(MUL_LAT + 3)) u_abc (
      .clock(clock), .en(en), .din({a_ff, b_ff, c_ff}), .dout(abc_d)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ac2_ff  <= sat_add(shift_sat(nac, pac, FRAC), shift_sat(nac, pac, FRAC));
         bb13_ff <= shift_sat(nbb, pbb, FRAC);
         ac4_ff  <= sat_add(ac2_ff, ac2_ff);
         bb14_ff <= bb13_ff;
         disc_ff <= sat_sub(bb14_ff, ac4_ff);
      end
   end

   assign coef.a    = q_type'(abc_d[3*QW-1:2*QW]);
   assign coef.b    = q_type'(abc_d[2*QW-1:QW]);
   assign coef.c    = q_type'(abc_d[QW-1:0]);
   assign coef.disc = disc_ff;

endmodule

>>> rtl/rpi_back.sv
module rpi_back import rpi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  qstat_type             qstat,
   input  coef_type              head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int D_C   = DIV_LAT + MUL_LAT + 1;
   localparam int D_FLG = 2 * DIV_LAT + MUL_LAT + 1;

   logic [BACK_LAT-1:0]   vld_ff;
   logic                  en;
   coef_type              cf_ff;
   logic [SQRT_STEPS-1:0] root;
   logic [3*QW:0]         s41;
   q_type                 a41, b41, c41;
   q_type                 nb_ff, nc_ff, a2_ff, c2_ff, root_ff, b42_ff;
   q_type                 a42_ff, c42_ff;
   logic                  lin42_ff, bz_ff, bpos_ff, dneg_ff;
   q_type                 num_in, den_in, dsum;
   logic                  ok_in;
   q_type                 num_ff, den_ff, a43_ff, c43_ff;
   logic                  ok43_ff, lin43_ff;
   q_type                 t1, t2, a109, c113, ad_ff, t1d;
   logic [PW-1:0]         pad;
   logic                  nad;
   logic [1:0]            flg;
   logic                  adnz;
   logic                  t1pos, t2pos, hit_in;
   q_type                 t_sel;
   logic                  hit_ff;
   logic [TIME_WIDTH-1:0] time_ff, time_in;

   assign en  = ~vld_ff[BACK_LAT-1] | rsp_tready;
   assign pop = en & ~qstat.empty;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[BACK_LAT-2:0], ~qstat.empty};
   end

   always_ff @(posedge clock) begin
      if (en) cf_ff <= head;
   end

   rpi_sqrt u_sqrt (
      .clock(clock), .en(en), .rad(cf_ff.disc[QW-1] ? q_type'(0) : cf_ff.disc), .root(root)
   );

   rpi_delay #(.WIDTH(3*QW+1), .DEPTH(SQRT_STEPS)) u_d_coef (
      .clock(clock), .en(en), .din({cf_ff.a, cf_ff.b, cf_ff.c, cf_ff.disc[QW-1]}), .dout(s41)
   );

   assign a41 = q_type'(s41[3*QW:2*QW+1]);
   assign b41 = q_type'(s41[2*QW:QW+1]);
   assign c41 = q_type'(s41[QW:1]);

   always_ff @(posedge clock) begin
      if (en) begin
         nb_ff    <= sat_neg(b41);
         nc_ff    <= sat_neg(c41);
         a2_ff    <= sat_add(a41, a41);
         c2_ff    <= sat_add(c41, c41);
         root_ff  <= QW'(root);
         a42_ff   <= a41;
         b42_ff   <= b41;
         c42_ff   <= c41;
         lin42_ff <= (a41 == '0);
         bz_ff    <= (b41 == '0);
         bpos_ff  <= ~b41[QW-1] && (b41 != '0);
         dneg_ff  <= s41[0];
      end
   end

   // linear root, stable root for positive b, stable root for other b
   always_comb begin
      dsum = sat_add(nb_ff, root_ff);
      if (lin42_ff) begin
         num_in = nc_ff;
         den_in = b42_ff;
         ok_in  = ~bz_ff;
      end else if (bpos_ff) begin
         num_in = sat_sub(nb_ff, root_ff);
         den_in = a2_ff;
         ok_in  = ~dneg_ff;
      end else begin
         num_in = c2_ff;
         den_in = dsum;
         ok_in  = ~dneg_ff && (dsum != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         den_ff   <= den_in;
         ok43_ff  <= ok_in;
         lin43_ff <= lin42_ff;
         a43_ff   <= a42_ff;
         c43_ff   <= c42_ff;
      end
   end

   rpi_div u_div1 (.clock(clock), .en(en), .num(num_ff), .den(den_ff), .quo(t1));

   rpi_delay #(.WIDTH(QW), .DEPTH(DIV_LAT)) u_d_a (
      .clock(clock), .en(en), .din(a43_ff), .dout(a109)
   );

   rpi_mul u_mul_at (.clock(clock), .en(en), .op_a(a109), .op_b(t1), .prod(pad), .neg(nad));

   always_ff @(posedge clock) begin
      if (en) ad_ff <= shift_sat(nad, pad, FRAC);
   end

   rpi_delay #(.WIDTH(QW), .DEPTH(D_C)) u_d_c (
      .clock(clock), .en(en), .din(c43_ff), .dout(c113)
   );

   rpi_div u_div2 (.clock(clock), .en(en), .num(c113), .den(ad_ff), .quo(t2));

   rpi_delay #(.WIDTH(QW), .DEPTH(MUL_LAT + 1 + DIV_LAT)) u_d_t1 (
      .clock(clock), .en(en), .din(t1), .dout(t1d)
   );

   rpi_delay #(.WIDTH(2), .DEPTH(D_FLG)) u_d_flg (
      .clock(clock), .en(en), .din({ok43_ff, lin43_ff}), .dout(flg)
   );

   rpi_delay #(.WIDTH(1), .DEPTH(DIV_LAT)) u_d_adnz (
      .clock(clock), .en(en), .din(ad_ff != '0), .dout(adnz)
   );

   always_comb begin
      t1pos = ~t1d[QW-1] && (t1d != '0);
      t2pos = ~t2[QW-1] && (t2 != '0);
      if (!flg[1]) begin
         hit_in = 1'b0;
         t_sel  = t1d;
      end else if (flg[0] || t1pos) begin
         hit_in = t1pos;
         t_sel  = t1d;
      end else begin
         hit_in = adnz && t2pos;
         t_sel  = t2;
      end
      if (!hit_in) time_in = '0;
      else if (t_sel > q_type'(TIME_MAX)) time_in = TIME_MAX;
      else time_in = t_sel[TIME_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_in;
         time_ff <= time_in;
      end
   end

   assign rsp_tvalid = vld_ff[BACK_LAT-1];
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = RSP_DATA_W'(time_ff);

endmodule

>>> rtl/ray_paraboloid_intersect.sv
// a req transfer reaches its rsp through the 15-stage coefficient pipeline,
// the queue and the 180-stage root pipeline
// throughput: one ray per cycle; the 40-stage square root and two 66-stage
// dividers are fully pipelined, one step per stage, unless rsp_tready stalls
// reset: synchronous, clears all valid flags, the queue and curvature to zero
module ray_paraboloid_intersect import rpi_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
   input  logic [((NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // hit
   output logic                                        rsp_tuser,
   // hit_time, zero pad
   output logic [RSP_DATA_W-1:0]                       rsp_tdata,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [CURV_WIDTH-1:0]                       csr_data
);

   logic signed [CURV_WIDTH-1:0] curv_ff;
   qstat_type                    qstat;
   coef_type                     coef, head;
   logic                         push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) curv_ff <= '0;
      else if (csr_valid) curv_ff <= csr_data;
   end

   rpi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .curv(curv_ff), .qstat(qstat), .push(push), .coef(coef)
   );

   rpi_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .wdata(coef), .pop(pop), .rdata(head),
      .stat(qstat)
   );

   rpi_back u_back (
      .clock(clock), .reset(reset), .qstat(qstat), .head(head), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

endmodule

>>> rtl/rpi_checker.sv
`include "ray_paraboloid_intersect_defines.svh"

module rpi_checker import rpi_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic                  rsp_tuser,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a miss carries no time
   `RPI_ASSERT(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
   // time never reaches the pad bit
   `RPI_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> !rsp_tdata[RSP_DATA_W-1])
   `RPI_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `RPI_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
   // after reset the pipeline is empty and open
   `RPI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind ray_paraboloid_intersect rpi_checker u_rpi_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import rpi_pkg::*;;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int REQ_W = ((NUM_FIELDS * CW + 7) / 8) * 8;
   localparam int LATENCY = 195;

   typedef logic signed [63:0] fx_type;

   typedef struct {
      logic [31:0] px, py, pz, vx, vy, vz;
   } ray_type;

   typedef struct {
      logic        hit;
      logic [30:0] t;
   } isect_type;

   typedef struct {
      ray_type     r;
      logic        known;
      logic        hit;
      logic [30:0] t;
   } drow_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic              rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [CURV_WIDTH-1:0] csr_data = '0;

   fx_type    curv_model;
   isect_type isect_q[$];
   int        errors = 0;
   bit        calm = 0;

   ray_paraboloid_intersect dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   function automatic fx_type s_add(fx_type a, fx_type b);
      fx_type s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      return s;
   endfunction

   function automatic fx_type s_sub(fx_type a, fx_type b);
      fx_type s = a - b;
      if (a[63] != b[63] && s[63] != a[63])
         s = a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      return s;
   endfunction

   function automatic fx_type s_neg(fx_type a);
      return a == 64'sh8000000000000000 ? 64'sh7fffffffffffffff : -a;
   endfunction

   function automatic fx_type to_sat(logic neg, logic [127:0] m);
      fx_type r;
      if (neg) r = (m > 128'h8000000000000000) ? 64'sh8000000000000000 : fx_type'(-m[63:0]);
      else r = (m > 128'h7fffffffffffffff) ? 64'sh7fffffffffffffff : fx_type'(m[63:0]);
      return r;
   endfunction

   function automatic logic [63:0] abs64(fx_type a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   function automatic fx_type fmul(fx_type a, fx_type b, int sh);
      logic [127:0] p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
      return to_sat(a[63] ^ b[63], p >> sh);
   endfunction

   function automatic fx_type fdiv(fx_type n, fx_type d);
      logic [127:0] q;
      if (d == 0) return 0;
      q = ({64'd0, abs64(n)} << 16) / {64'd0, abs64(d)};
      return to_sat(n[63] ^ d[63], q);
   endfunction

   function automatic fx_type fsqrt(fx_type d);
      logic [127:0] tgt = {64'd0, d} << 16;
      logic [127:0] r = 0, c;
      for (int i = 39; i >= 0; i--) begin
         c = r | (128'd1 << i);
         if (c * c <= tgt) r = c;
      end
      return fx_type'(r[63:0]);
   endfunction

   function automatic isect_type trace(ray_type r);
      fx_type x, y, z, vx, vy, vz, k, a, b, c, t, disc, root, num, den, ac, ac4, ad;
      logic hit, ok;
      isect_type o;
      x = fx_type'(signed'(r.px)); y = fx_type'(signed'(r.py)); z = fx_type'(signed'(r.pz));
      vx = fx_type'(signed'(r.vx)); vy = fx_type'(signed'(r.vy));
      vz = fx_type'(signed'(r.vz));
      k = curv_model;
      t = 0;
      hit = 0;
      a = fmul(s_add(fmul(vx, vx, 16), fmul(vy, vy, 16)), k, 25);
      b = s_sub(fmul(s_add(fmul(x, vx, 16), fmul(y, vy, 16)), k, 24), vz);
      c = s_sub(fmul(s_add(fmul(x, x, 16), fmul(y, y, 16)), k, 25), z);
      if (a == 0) begin
         if (b != 0) begin
            t = fdiv(s_neg(c), b);
            hit = t > 0;
         end
      end else begin
         ac = fmul(a, c, 16);
         ac4 = s_add(s_add(ac, ac), s_add(ac, ac));
         disc = s_sub(fmul(b, b, 16), ac4);
         if (disc >= 0) begin
            ok = 1;
            root = fsqrt(disc);
            if (b > 0) begin
               num = s_sub(s_neg(b), root);
               den = s_add(a, a);
            end else begin
               num = s_add(c, c);
               den = s_add(s_neg(b), root);
               if (den == 0) ok = 0;
            end
            if (ok) begin
               t = fdiv(num, den);
               if (t > 0) hit = 1;
               else begin
                  ad = fmul(a, t, 16);
                  if (ad != 0) begin
                     t = fdiv(c, ad);
                     hit = t > 0;
                  end
               end
            end
         end
      end
      o.hit = hit;
      o.t = !hit ? 31'd0 : (t > 64'sh7fffffff ? 31'h7fffffff : t[30:0]);
      return o;
   endfunction

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
         2: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
         default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
   endfunction

   task automatic idle_gap();
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
   endtask

   task automatic set_curvature(logic [31:0] k);
      @(posedge clock);
      csr_valid <= 1;
      csr_data <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      curv_model = fx_type'(signed'(k));
   endtask

   task automatic send_ray(ray_type r, logic known, logic hit, logic [30:0] t);
      isect_type e;
      idle_gap();
      req_tvalid <= 1;
      req_tdata <= {r.vz, r.vy, r.vx, r.pz, r.py, r.px};
      do @(posedge clock); while (!req_tready);
      e = trace(r);
      if (known) begin
         e.hit = hit;
         e.t = t;
      end
      isect_q.push_back(e);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (isect_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   always @(posedge clock) begin
      isect_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (isect_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer hit=%0d t=%h", rsp_tuser, rsp_tdata);
         end else begin
            e = isect_q.pop_front();
            if (rsp_tuser !== e.hit || rsp_tdata !== {1'b0, e.t}) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp hit=%0d t=%h got hit=%0d t=%h",
                           e.hit, e.t, rsp_tuser, rsp_tdata);
            end
         end
      end
   end

   initial begin
      drow_type dirs[$];
      drow_type d;
      ray_type r;
      logic [31:0] curvs[6];
      curv_model = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // flat plane after reset: t = z / -vz
      d = '{r: '{0, 0, 32'hfffb0000, 0, 0, 32'h00010000}, known: 1, hit: 1, t: 31'h50000};
      dirs.push_back(d);
      d = '{r: '{0, 0, 32'h00050000, 0, 0, 32'h00010000}, known: 1, hit: 0, t: 0};
      dirs.push_back(d);
      d = '{r: '{0, 0, 32'h00050000, 0, 0, 0}, known: 1, hit: 0, t: 0};
      dirs.push_back(d);
      d = '{r: '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h00000001}, known: 1, hit: 1, t: 31'h7fffffff};
      dirs.push_back(d);
      d = '{r: '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000}, known: 0, hit: 0, t: 0};
      dirs.push_back(d);
      foreach (dirs[i]) send_ray(dirs[i].r, dirs[i].known, dirs[i].hit, dirs[i].t);
      drain();

      curvs = '{32'h01000000, 32'hff000000, 32'h7fffffff, 32'h80000000, 32'h00100000, 0};
      foreach (curvs[ci]) begin
         set_curvature(curvs[ci]);
         // directed: axial, vertical, grazing, tangent and miss rays
         for (int j = 0; j < 4; j++) begin
            r = '{0, 0, 32'($signed(j - 2)) << 16, 0, 0, 32'h00010000};
            send_ray(r, 0, 0, 0);
            r = '{32'h00010000 << j, 0, 32'hfff00000, 0, 0, 32'hffff0000};
            send_ray(r, 0, 0, 0);
            r = '{0, 32'h00020000, 32'h00010000, 32'h00010000 << j, 0, 0};
            send_ray(r, 0, 0, 0);
         end
         for (int n = 0; n < 170; n++) begin
            calm = (ci == 2) && n >= 40 && n < 120;
            r = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord()};
            send_ray(r, 0, 0, 0);
         end
         calm = 0;
         drain();
      end
      if (errors == 0 && isect_q.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/rpi_pkg.sv
rtl/rpi_delay.sv
rtl/rpi_mul.sv
rtl/rpi_sqrt.sv
rtl/rpi_div.sv
rtl/rpi_fifo.sv
rtl/rpi_front.sv
rtl/rpi_back.sv
rtl/ray_paraboloid_intersect.sv
rtl/rpi_checker.sv
test/tb_top.sv
